[rtl/core/can_error_classify_burst_detect_unit_defines.svh]
// Assertion macros shared by the error classifier RTL.
`ifndef CAN_ERROR_CLASSIFY_BURST_DETECT_UNIT_DEFINES_SVH
`define CAN_ERROR_CLASSIFY_BURST_DETECT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define CECBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held
`define CECBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cecbd_pkg.sv]
// Types, constants and the class encoder for the CAN error classifier.
package cecbd_pkg;

  localparam int NUM_CLASSES = 10;
  localparam int CLASS_W     = 4;
  localparam int COUNT_W     = 32;
  localparam int TIME_W      = 64;
  localparam int ID_W        = 29;
  localparam int THR_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 4'd9;

  localparam logic [THR_W-1:0]  THR_RESET    = 7'd8;
  localparam logic [TIME_W-1:0] WINDOW_RESET = 64'd1000000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_WINDOW    = 1'b1;

  typedef struct packed {
    logic              mode;
    logic              is_error_frame;
    logic [ID_W-1:0]   frame_id;
    logic [TIME_W-1:0] frame_time_us;
  } in_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] error_class;
    logic [COUNT_W-1:0] class_count;
    logic [COUNT_W-1:0] total_count;
    logic [TIME_W-1:0]  latest_time_us;
    logic               burst_flag;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PRIME,
    ST_WALK,
    ST_DONE
  } state_t;

  // Priority encoder: lowest set flag bit wins, none set means unknown
  function automatic logic [CLASS_W-1:0] classify(input logic [ID_W-1:0] id);
    logic [CLASS_W-1:0] cls;
    cls = CLASS_UNKNOWN;
    for (int b = 8; b >= 0; b--) begin
      if (id[b]) begin
        cls = CLASS_W'(b);
      end
    end
    return cls;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

[rtl/core/can_error_classify_burst_detect_unit.sv]
// Top level: CAN error frame classifier with ring-buffer burst detector.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------
//  in_     | in        | in_valid/in_stall | in_data   (in_item_t)
//  out_    | out       | out_valid/out_stall| out_data (out_item_t)
//  cfg_    | in        | cfg_we            | cfg_index, cfg_wdata
//
// An error frame walks the ring from the newest entry back, skipping the walk
// when the total is below the threshold and stopping at the threshold, at an
// entry outside the window or after the last stored event; the walk reads one
// ring entry a cycle through the single RAM read port and one 64-bit
// subtract-compare. A result held by out_stall keeps the frame in its last
// step. Clear and non-error items are handled in ST_IDLE. in_stall is high
// while a frame is being worked on. The ring needs no clearing pass: only
// written entries are ever walked. Reset is synchronous, active low.
`include "can_error_classify_burst_detect_unit_defines.svh"

module can_error_classify_burst_detect_unit #(
  parameter int EVENT_DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  cecbd_pkg::in_item_t                       in_data,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output cecbd_pkg::out_item_t                      out_data,
  input  logic                                      cfg_we,
  input  logic [cecbd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [cecbd_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

  import cecbd_pkg::*;

  localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int SW = $clog2(EVENT_DEPTH + 1);
  localparam int CW = ((SW > THR_W) ? SW : THR_W) + 1;
  localparam logic [AW-1:0] LAST_PTR  = AW'(EVENT_DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_CNT = SW'(EVENT_DEPTH);

  // Config registers
  logic [THR_W-1:0]  thr_r;
  logic [TIME_W-1:0] window_r;

  // Control and statistics
  state_t             state_r, state_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [SW-1:0]      stored_r, stored_nxt;
  logic [SW-1:0]      walk_cnt_r, walk_cnt_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic [TIME_W-1:0]  latest_r, latest_nxt;
  logic               burst_r, burst_nxt;
  logic [COUNT_W-1:0] cls_cnt_r [NUM_CLASSES];
  logic               out_valid_r, out_valid_nxt;

  // Item payload
  logic [TIME_W-1:0]  ts_r;
  logic [CLASS_W-1:0] cls_r;
  out_item_t          out_data_r;

  // Datapath controls
  logic               accept;
  logic               cls_clr, cls_inc, out_load;
  logic               ram_we;
  logic [AW-1:0]      ram_rd_addr;
  logic [TIME_W-1:0]  ram_rd_data;
  logic [THR_W-1:0]   need;
  logic [TIME_W-1:0]  age;
  logic               in_win;
  logic [SW-1:0]      walk_next;
  logic               reached;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Threshold zero counts as one
  assign need      = (thr_r == '0) ? THR_W'(1) : thr_r;

  // Shared window unit: age of the entry under the walk
  assign age       = latest_r - ram_rd_data;
  assign in_win    = (age <= window_r);
  assign walk_next = walk_cnt_r + SW'(1);
  assign reached   = (CW'(walk_next) >= CW'(need));

  // Event ring
  cecbd_ram #(
    .WIDTH (TIME_W),
    .DEPTH (EVENT_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wp_r),
    .wr_data (ts_r),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !in_data.mode && in_data.is_error_frame) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_PRIME;
      ST_PRIME: begin
        if (total_r < COUNT_W'(need)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!in_win || reached || (walk_next >= stored_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls and register next values
  always_comb begin
    wp_nxt        = wp_r;
    rd_ptr_nxt    = rd_ptr_r;
    stored_nxt    = stored_r;
    walk_cnt_nxt  = walk_cnt_r;
    total_nxt     = total_r;
    latest_nxt    = latest_r;
    burst_nxt     = burst_r;
    out_valid_nxt = out_valid_r && out_stall;
    cls_clr       = 1'b0;
    cls_inc       = 1'b0;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_rd_addr   = rd_ptr_r;
    case (state_r)
      ST_IDLE: begin
        // clear mode wipes statistics; the ring contents are left stale
        if (accept && in_data.mode) begin
          wp_nxt     = '0;
          stored_nxt = '0;
          total_nxt  = '0;
          latest_nxt = '0;
          cls_clr    = 1'b1;
        end
      end
      ST_UPDATE: begin
        ram_we       = 1'b1;
        wp_nxt       = (wp_r == LAST_PTR) ? '0 : wp_r + AW'(1);
        stored_nxt   = (stored_r == DEPTH_CNT) ? stored_r : stored_r + SW'(1);
        cls_inc      = 1'b1;
        total_nxt    = sat_inc(total_r);
        latest_nxt   = (ts_r > latest_r) ? ts_r : latest_r;
        rd_ptr_nxt   = wp_r;
        walk_cnt_nxt = '0;
        burst_nxt    = 1'b0;
      end
      ST_PRIME: begin
        // fetch newest entry
        rd_ptr_nxt = (rd_ptr_r == '0) ? LAST_PTR : rd_ptr_r - AW'(1);
      end
      ST_WALK: begin
        // compare this entry, fetch the next older one
        rd_ptr_nxt   = (rd_ptr_r == '0) ? LAST_PTR : rd_ptr_r - AW'(1);
        walk_cnt_nxt = walk_next;
        burst_nxt    = in_win && reached;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rd_ptr_r    <= '0;
      stored_r    <= '0;
      walk_cnt_r  <= '0;
      total_r     <= '0;
      latest_r    <= '0;
      burst_r     <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
      window_r    <= WINDOW_RESET;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cls_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      stored_r    <= stored_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      total_r     <= total_nxt;
      latest_r    <= latest_nxt;
      burst_r     <= burst_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BURST_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
          CFG_BURST_WINDOW:    window_r <= cfg_wdata[TIME_W-1:0];
          default: ;
        endcase
      end
      if (cls_clr) begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
          cls_cnt_r[i] <= '0;
        end
      end else if (cls_inc) begin
        cls_cnt_r[cls_r] <= sat_inc(cls_cnt_r[cls_r]);
      end
    end
  end

  // Item capture and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      ts_r  <= in_data.frame_time_us;
      cls_r <= classify(in_data.frame_id);
    end
    if (out_load) begin
      out_data_r.error_class    <= cls_r;
      out_data_r.class_count    <= cls_cnt_r[cls_r];
      out_data_r.total_count    <= total_r;
      out_data_r.latest_time_us <= latest_r;
      out_data_r.burst_flag     <= burst_r;
    end
  end

  // Checks
  `CECBD_ASSERT_NOW(a_walk_in_range, clk, rst_n, state_r == ST_WALK, walk_cnt_r < stored_r, "walk past stored events")
  `CECBD_ASSERT_NOW(a_stored_bound, clk, rst_n, 1'b1, stored_r <= DEPTH_CNT, "stored events above ring depth")
  `CECBD_ASSERT_NEXT(a_done_holds, clk, rst_n, (state_r == ST_DONE) && out_valid_r && out_stall, state_r == ST_DONE, "result dropped while output stalled")
  `CECBD_ASSERT_NOW(a_total_nonzero, clk, rst_n, out_valid_r, out_data_r.total_count != '0, "result with zero total")

endmodule

[rtl/core/cecbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cecbd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
